FILE: rtl/rpv_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the ribbon vertex generator.
// No dependencies; every other file of the block imports this package.
package rpv_pkg;

	localparam int VEC_W  = 33;   // normalizer input component
	localparam int NUM_W  = 36;   // divider numerator
	localparam int DEN_W  = 22;   // divider denominator
	localparam int QUO_W  = 33;   // divider quotient
	localparam int STEP_W = 6;    // divider step count
	localparam int ONE_Q14 = 16384;
	localparam int TEXU_ONE = 65536;

	// Configuration register indexes.
	localparam logic REG_PATH_WIDTH = 1'b0;
	localparam logic REG_LAST_INDEX = 1'b1;

	typedef logic signed [VEC_W-1:0] comp_t;
	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SHIFT,
		U_SQ,
		U_SQRT,
		U_DIV,
		U_DIVW,
		U_DONE
	} unit_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_DIR,
		T_DIR_W,
		T_TAN,
		T_TAN_W,
		T_SIDE,
		T_SIDE_W,
		T_SCALE,
		T_CROSS,
		T_NRM,
		T_NRM_W,
		T_TEXU,
		T_TEXU_W,
		T_OUT_L,
		T_OUT_R,
		T_NEXT
	} top_state_t;

endpackage

FILE: rtl/rpv_div.sv
`timescale 1ns / 1ps
// Serial restoring divider, one quotient bit per cycle.
// Depends on rpv_pkg for the request and response structs.
module rpv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rpv_pkg::div_req_t req,
	output rpv_pkg::div_rsp_t rsp
);
	import rpv_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [QUO_W-1:0]  quo_q;
	logic [STEP_W-1:0] bit_idx;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	always_comb begin
		bit_idx = cnt_q - STEP_W'(1);
		trial   = {rem_q, num_q[bit_idx]};
		diff    = trial - {1'b0, den_q};
		ge      = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// The caller keeps the high part below the divisor.
			rem_q <= DEN_W'(req.num >> req.steps);
			den_q <= req.den;
			num_q <= req.num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

FILE: rtl/rpv_unit.sv
`timescale 1ns / 1ps
// Vector normalizer: block scaling, sum of squares, bit-serial square root,
// and three divisions through the shared divider. Depends on rpv_pkg.
module rpv_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rpv_pkg::comp_t    vec [3],
	output logic              done,
	output rpv_pkg::q14_t     res [3],
	output rpv_pkg::div_req_t div_req,
	input  rpv_pkg::div_rsp_t div_rsp
);
	import rpv_pkg::*;

	unit_state_t state_q, state_d;
	logic [VEC_W-1:0] a_q [3];
	logic             neg_q [3];
	logic [43:0]      s_q;
	logic [43:0]      r_q;
	logic [4:0]       be_q;
	logic [1:0]       k_q;
	q14_t             res_q [3];
	logic [VEC_W-1:0] m;
	logic [41:0]      sq;
	logic [43:0]      bitv;
	logic [44:0]      trial;
	logic [14:0]      qv;

	always_comb begin
		m = a_q[0];
		if (a_q[1] > m) m = a_q[1];
		if (a_q[2] > m) m = a_q[2];
		sq    = a_q[k_q][20:0] * a_q[k_q][20:0];
		bitv  = 44'(1) << {be_q, 1'b0};
		trial = {1'b0, r_q} + {1'b0, bitv};
		qv    = (div_rsp.quo > QUO_W'(ONE_Q14)) ? 15'(ONE_Q14) : div_rsp.quo[14:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE:  if (start) state_d = U_SHIFT;
			U_SHIFT: begin
				if (m == '0)
					state_d = U_DONE;
				else if (m >= VEC_W'(1 << 20) && m < VEC_W'(1 << 21))
					state_d = U_SQ;
			end
			U_SQ:    if (k_q == 2'd2) state_d = U_SQRT;
			U_SQRT:  if (be_q == '0) state_d = U_DIV;
			U_DIV:   state_d = U_DIVW;
			U_DIVW:  if (div_rsp.done) state_d = (k_q == 2'd2) ? U_DONE : U_DIV;
			U_DONE:  state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		done          = state_q == U_DONE;
		div_req.start = state_q == U_DIV;
		div_req.num   = NUM_W'({a_q[k_q][20:0], 14'b0}) + NUM_W'(r_q[21:1]);
		div_req.den   = r_q[DEN_W-1:0];
		div_req.steps = STEP_W'(15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= U_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (start) begin
					for (int k = 0; k < 3; k++) begin
						neg_q[k] <= vec[k][VEC_W-1];
						a_q[k]   <= vec[k][VEC_W-1] ? VEC_W'(-vec[k]) : vec[k];
					end
					s_q <= '0;
					k_q <= '0;
				end
			end
			U_SHIFT: begin
				// Coarse steps of four keep the same truncation as single steps.
				if (m == '0) begin
					for (int k = 0; k < 3; k++) res_q[k] <= '0;
				end else if (m >= VEC_W'(1 << 25)) begin
					for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] >> 4;
				end else if (m >= VEC_W'(1 << 21)) begin
					for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] >> 1;
				end else if (m < VEC_W'(1 << 16)) begin
					for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] << 4;
				end else if (m < VEC_W'(1 << 20)) begin
					for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] << 1;
				end
			end
			U_SQ: begin
				s_q  <= s_q + 44'(sq);
				k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				r_q  <= '0;
				be_q <= 5'd21;
			end
			U_SQRT: begin
				if ({1'b0, s_q} >= trial) begin
					s_q <= s_q - trial[43:0];
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				be_q <= be_q - 5'd1;
			end
			U_DIVW: begin
				if (div_rsp.done) begin
					res_q[k_q] <= neg_q[k_q] ? -q14_t'(qv) : q14_t'(qv);
					k_q <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;

endmodule

FILE: rtl/path_ribbon_vertex_gen.sv
`timescale 1ns / 1ps
// Top level of the polyline ribbon vertex generator: sequencer, side and
// cross product datapath, output register. Depends on rpv_pkg, rpv_unit, rpv_div.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_ready  point_x/y/z, final_point
//  out       source     out_valid/out_ready  pos, normal, tex_u/v, vertex_index,
//                                            last_of_run
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
// One beat is handled at a time; in_ready is high only while the sequencer idles.
// A first point of a path is only stored. For a later point the segment
// direction and the interior tangent take one normalizer pass each, and every
// emitted point takes two more (a 22 step square root and three 15 step
// divisions each; the normal pass is skipped at zero width) plus a 33 step
// division for tex_u.
// The output register lets a result beat wait while work goes on; the
// sequencer stalls only when a new vertex finds it still occupied.
// Reset clears the path state and loads the register defaults.
module path_ribbon_vertex_gen #(
	parameter int MAX_POINTS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               final_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic               tex_v,
	output logic [16:0]        vertex_index,
	output logic               last_of_run,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);
	import rpv_pkg::*;

	localparam int IDXW  = $clog2(MAX_POINTS);
	localparam int SEENW = $clog2(MAX_POINTS + 1);

	top_state_t state_q, state_d;

	// Registers and path state.
	logic [31:0]       pw_q;
	logic [15:0]       li_q;
	logic [SEENW-1:0]  seen_q;
	logic signed [31:0] held_q [3];
	q14_t              prior_q [3];

	// Per-beat context.
	logic signed [31:0] p_q [3];
	logic              fin_q;
	logic              second_q;
	q14_t              dir_q [3];
	q14_t              tan_q [3];
	q14_t              su_q [3];
	q14_t              nrm_q [3];
	comp_t             sv_q [3];
	comp_t             cr_q [3];
	logic [32:0]       acc_q;
	logic [2:0]        cnt_q;
	logic [16:0]       u_q;
	logic              out_valid_q;

	// Normalizer and divider hookup.
	logic              u_start;
	comp_t             u_vec [3];
	logic              u_done;
	q14_t              u_res [3];
	div_req_t          unit_div_req;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Emit point selection and arithmetic.
	logic signed [31:0] ept [3];
	q14_t              etan [3];
	logic [IDXW-1:0]   eidx;
	logic              elast;
	logic [15:0]       li_eff;
	logic signed [32:0] ma;
	logic signed [16:0] mb;
	logic signed [49:0] mprod;
	logic [49:0]       mag_sum;
	logic [31:0]       mag;
	logic [15:0]       su_mag;
	logic [32:0]       cr_diff;
	logic              accept;
	logic              out_free;
	logic signed [31:0] lpos [3];
	logic signed [31:0] rpos [3];

	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > 34'sd2147483647)       r = 32'sh7fffffff;
		else if (x < -34'sd2147483648) r = 32'sh80000000;
		else                           r = x[31:0];
		return r;
	endfunction

	always_comb begin
		accept   = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;
		for (int k = 0; k < 3; k++) begin
			ept[k]  = second_q ? p_q[k] : held_q[k];
			etan[k] = second_q ? dir_q[k] : tan_q[k];
			lpos[k] = sat32(34'(ept[k]) - 34'(sv_q[k]));
			rpos[k] = sat32(34'(ept[k]) + 34'(sv_q[k]));
		end
		// Point index of the emitted point, held at the last index once the
		// path runs past MAX_POINTS.
		if (second_q)
			eidx = (seen_q >= SEENW'(MAX_POINTS)) ? IDXW'(MAX_POINTS - 1) : IDXW'(seen_q);
		else
			eidx = IDXW'(seen_q - SEENW'(1));
		elast  = second_q || !fin_q;
		li_eff = (li_q == '0) ? 16'd1 : li_q;
	end

	// Shared multiplier: side scaling by the path width, then the cross product.
	always_comb begin
		su_mag = su_q[cnt_q[1:0]][15] ? 16'(-su_q[cnt_q[1:0]]) : su_q[cnt_q[1:0]];
		ma = 33'(etan[1]);
		mb = 17'(su_q[2]);
		if (state_q == T_SCALE) begin
			ma = $signed({1'b0, pw_q});
			mb = $signed({1'b0, su_mag});
		end else begin
			case (cnt_q)
				3'd0: begin ma = 33'(etan[1]); mb = 17'(su_q[2]); end
				3'd1: begin ma = 33'(etan[2]); mb = 17'(su_q[1]); end
				3'd2: begin ma = 33'(etan[2]); mb = 17'(su_q[0]); end
				3'd3: begin ma = 33'(etan[0]); mb = 17'(su_q[2]); end
				3'd4: begin ma = 33'(etan[0]); mb = 17'(su_q[1]); end
				3'd5: begin ma = 33'(etan[1]); mb = 17'(su_q[0]); end
				default: begin ma = 33'(etan[1]); mb = 17'(su_q[2]); end
			endcase
		end
		mprod   = ma * mb;
		mag_sum = mprod + 50'sd16384;
		mag     = mag_sum[46:15];
		cr_diff = acc_q - mprod[32:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:   if (accept && seen_q != '0) state_d = T_DIR;
			T_DIR:    state_d = T_DIR_W;
			T_DIR_W:  if (u_done) state_d = (seen_q == SEENW'(1)) ? T_SIDE : T_TAN;
			T_TAN:    state_d = T_TAN_W;
			T_TAN_W:  if (u_done) state_d = T_SIDE;
			T_SIDE:   state_d = T_SIDE_W;
			T_SIDE_W: if (u_done) state_d = T_SCALE;
			T_SCALE:  if (cnt_q == 3'd2) state_d = T_CROSS;
			T_CROSS: begin
				if (pw_q == '0)          state_d = T_TEXU;
				else if (cnt_q == 3'd5)  state_d = T_NRM;
			end
			T_NRM:    state_d = T_NRM_W;
			T_NRM_W:  if (u_done) state_d = T_TEXU;
			T_TEXU:   state_d = T_TEXU_W;
			T_TEXU_W: if (div_rsp.done) state_d = T_OUT_L;
			T_OUT_L:  if (out_free) state_d = T_OUT_R;
			T_OUT_R:  if (out_free) state_d = T_NEXT;
			T_NEXT:   state_d = (fin_q && !second_q) ? T_SIDE : T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready = state_q == T_IDLE;
		u_start  = (state_q == T_DIR) || (state_q == T_TAN) ||
		           (state_q == T_SIDE) || (state_q == T_NRM);
		for (int k = 0; k < 3; k++) u_vec[k] = cr_q[k];
		case (state_q)
			T_DIR: begin
				for (int k = 0; k < 3; k++) u_vec[k] = 33'(p_q[k]) - 33'(held_q[k]);
			end
			T_TAN: begin
				for (int k = 0; k < 3; k++) u_vec[k] = 33'(prior_q[k]) + 33'(dir_q[k]);
			end
			T_SIDE: begin
				u_vec[0] = 33'(etan[2]);
				u_vec[1] = '0;
				u_vec[2] = -33'(etan[0]);
			end
			default: ;
		endcase
		if (state_q == T_TEXU) begin
			div_req.start = 1'b1;
			div_req.num   = (NUM_W'(eidx) << 16) + NUM_W'(li_eff >> 1);
			div_req.den   = DEN_W'(li_eff);
			div_req.steps = STEP_W'(QUO_W);
		end else begin
			div_req = unit_div_req;
		end
	end

	rpv_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (u_start),
		.vec     (u_vec),
		.done    (u_done),
		.res     (u_res),
		.div_req (unit_div_req),
		.div_rsp (div_rsp)
	);

	rpv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control state: sequencer, registers, path count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			pw_q        <= 32'd65536;
			li_q        <= 16'd1;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_PATH_WIDTH: pw_q <= cfg_data;
					REG_LAST_INDEX: li_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept && seen_q == '0)
				seen_q <= final_point ? '0 : SEENW'(1);
			if (state_q == T_NEXT && !(fin_q && !second_q)) begin
				if (fin_q)
					seen_q <= '0;
				else if (seen_q < SEENW'(MAX_POINTS))
					seen_q <= seen_q + SEENW'(1);
			end
			if ((state_q == T_OUT_L || state_q == T_OUT_R) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					p_q[0]   <= point_x;
					p_q[1]   <= point_y;
					p_q[2]   <= point_z;
					fin_q    <= final_point;
					second_q <= 1'b0;
					if (seen_q == '0) begin
						held_q[0] <= point_x;
						held_q[1] <= point_y;
						held_q[2] <= point_z;
					end
				end
			end
			T_DIR_W: begin
				if (u_done) begin
					dir_q <= u_res;
					tan_q <= u_res;
				end
			end
			T_TAN_W:  if (u_done) tan_q <= u_res;
			T_SIDE_W: begin
				if (u_done) begin
					su_q  <= u_res;
					cnt_q <= '0;
				end
			end
			T_SCALE: begin
				sv_q[cnt_q[1:0]] <= su_q[cnt_q[1:0]][15] ? -comp_t'({1'b0, mag})
				                                         : comp_t'({1'b0, mag});
				cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
			end
			T_CROSS: begin
				// Zero width leaves a zero side vector, and the normal is zero too.
				if (pw_q == '0) begin
					for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
				end else begin
					if (cnt_q[0] == 1'b0) acc_q <= mprod[32:0];
					else                  cr_q[cnt_q[2:1]] <= comp_t'(cr_diff);
					cnt_q <= cnt_q + 3'd1;
				end
			end
			T_NRM_W:  if (u_done) nrm_q <= u_res;
			T_TEXU_W: begin
				if (div_rsp.done)
					u_q <= (div_rsp.quo > QUO_W'(TEXU_ONE)) ? 17'(TEXU_ONE)
					                                          : div_rsp.quo[16:0];
			end
			T_NEXT: begin
				if (!fin_q) begin
					held_q  <= p_q;
					prior_q <= dir_q;
				end
				if (fin_q && !second_q) second_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Output register: left vertex first, then right.
	always_ff @(posedge clk) begin
		if ((state_q == T_OUT_L || state_q == T_OUT_R) && out_free) begin
			if (state_q == T_OUT_L) begin
				pos_x <= lpos[0];
				pos_y <= lpos[1];
				pos_z <= lpos[2];
			end else begin
				pos_x <= rpos[0];
				pos_y <= rpos[1];
				pos_z <= rpos[2];
			end
			normal_x     <= nrm_q[0];
			normal_y     <= nrm_q[1];
			normal_z     <= nrm_q[2];
			tex_u        <= u_q;
			tex_v        <= state_q == T_OUT_R;
			vertex_index <= 17'({eidx, state_q == T_OUT_R});
			last_of_run  <= (state_q == T_OUT_R) && elast;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_unit_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (state_q == T_DIR_W || state_q == T_TAN_W ||
		            state_q == T_SIDE_W || state_q == T_NRM_W))
		else $error("normalizer finished while the sequencer was not waiting");

	a_single_point_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && seen_q == '0 && final_point) |=> (seen_q == '0 && state_q == T_IDLE))
		else $error("single point path left state behind");

	a_texu_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tex_u <= 17'(TEXU_ONE)))
		else $error("tex_u above one");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for path_ribbon_vertex_gen: drives polyline points and
// checks every vertex beat against a predictor of the ribbon extrusion.
// Depends on rpv_pkg (register indexes, ONE_Q14 and TEXU_ONE) and the block's RTL.
module tb;
	import rpv_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int DRAIN_CYCLES = 1000;   // longer than a final point takes
	localparam int STALL_LIMIT  = 20000;  // cycles with no beat on either channel
	localparam int HOLD_CYCLES  = 3000;

	typedef longint v3_t [3];

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [16:0]        u;
		logic               v;
		logic [16:0]        vi;
		logic               last;
	} vertex_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               fin;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic final_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [16:0] tex_u, vertex_index;
	logic tex_v, last_of_run;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_PATH_WIDTH;
	logic [31:0] cfg_data = '0;

	path_ribbon_vertex_gen u_top (.*);

	// The predictor's copy of the registers and of the path state.
	longint unsigned ribbon_width = 65536;
	longint unsigned u_divisor = 1;
	v3_t held_pt = '{0, 0, 0};
	v3_t prev_dir = '{0, 0, 0};
	int pts_in_path = 0;

	vertex_t pending_vertices[$];
	int mismatches = 0;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// A 12 ns clock, high and low for half a period each.
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Unit vector in Q2.14. The largest magnitude is brought into [2^20, 2^21)
	// first, so the square root always sees the same precision. Zero stays zero.
	function automatic v3_t unit_vec(v3_t v);
		longint unsigned a[3];
		longint unsigned m, n, s, q;
		bit neg[3];
		v3_t o;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			neg[k] = v[k] < 0;
			a[k] = neg[k] ? -v[k] : v[k];
			if (a[k] > m)
				m = a[k];
		end
		if (m == 0)
			return '{0, 0, 0};
		while (m >= (64'd1 << 21)) begin
			m >>= 1;
			for (int k = 0; k < 3; k++)
				a[k] >>= 1;
		end
		while (m < (64'd1 << 20)) begin
			m <<= 1;
			for (int k = 0; k < 3; k++)
				a[k] <<= 1;
		end
		s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		n = isqrt(s);
		for (int k = 0; k < 3; k++) begin
			q = (a[k] * ONE_Q14 + n / 2) / n;
			if (q > ONE_Q14)
				q = ONE_Q14;
			o[k] = neg[k] ? -longint'(q) : longint'(q);
		end
		return o;
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// Appends one vertex at the tail of the expected queue.
	function automatic void queue_vertex(vertex_t w);
		pending_vertices = {pending_vertices, w};
	endfunction

	// Queues the left and right vertex of one point with tangent t.
	function automatic void expect_point(v3_t p, v3_t t, int idx, bit last);
		v3_t side, su, cr, nrm, lp, rp;
		longint unsigned mag, li, u;
		vertex_t w;
		side = '{t[2], 0, -t[0]};
		su = unit_vec(side);
		for (int k = 0; k < 3; k++) begin
			mag = su[k] < 0 ? -su[k] : su[k];
			mag = (mag * ribbon_width + (64'd1 << 14)) >> 15;
			side[k] = su[k] < 0 ? -longint'(mag) : longint'(mag);
			lp[k] = sat32(p[k] - side[k]);
			rp[k] = sat32(p[k] + side[k]);
		end
		if (ribbon_width == 0) begin
			nrm = '{0, 0, 0};
		end else begin
			cr[0] = t[1] * su[2] - t[2] * su[1];
			cr[1] = t[2] * su[0] - t[0] * su[2];
			cr[2] = t[0] * su[1] - t[1] * su[0];
			nrm = unit_vec(cr);
		end
		li = u_divisor == 0 ? 1 : u_divisor;
		u = (longint'(idx) * 65536 + li / 2) / li;
		if (u > TEXU_ONE)
			u = TEXU_ONE;
		w.nx = nrm[0][15:0];
		w.ny = nrm[1][15:0];
		w.nz = nrm[2][15:0];
		w.u = u[16:0];
		w.px = lp[0][31:0];
		w.py = lp[1][31:0];
		w.pz = lp[2][31:0];
		w.v = 1'b0;
		w.vi = 17'(2 * idx);
		w.last = 1'b0;
		queue_vertex(w);
		w.px = rp[0][31:0];
		w.py = rp[1][31:0];
		w.pz = rp[2][31:0];
		w.v = 1'b1;
		w.vi = 17'(2 * idx + 1);
		w.last = last;
		queue_vertex(w);
	endfunction

	function automatic int clamp_idx(int i);
		return i > 65535 ? 65535 : i;
	endfunction

	function automatic void clear_path();
		held_pt = '{0, 0, 0};
		prev_dir = '{0, 0, 0};
		pts_in_path = 0;
	endfunction

	// One accepted point: a point is emitted once the next one fixes its tangent.
	function automatic void predict_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic fin);
		v3_t p, d, dir, tan, sum;
		p = '{longint'(x), longint'(y), longint'(z)};
		if (pts_in_path == 0) begin
			if (fin) begin
				clear_path();
			end else begin
				held_pt = p;
				pts_in_path = 1;
			end
			return;
		end
		for (int k = 0; k < 3; k++)
			d[k] = p[k] - held_pt[k];
		dir = unit_vec(d);
		if (pts_in_path == 1) begin
			tan = dir;
		end else begin
			for (int k = 0; k < 3; k++)
				sum[k] = prev_dir[k] + dir[k];
			tan = unit_vec(sum);
		end
		expect_point(held_pt, tan, clamp_idx(pts_in_path - 1), !fin);
		if (fin) begin
			expect_point(p, dir, clamp_idx(pts_in_path), 1'b1);
			clear_path();
		end else begin
			held_pt = p;
			prev_dir = dir;
			if (pts_in_path < 65536)
				pts_in_path++;
		end
	endfunction

	task automatic report_mismatch(string what, vertex_t got, vertex_t want);
		mismatches++;
		$write("%0t %s: got pos %0d %0d %0d n %0d %0d %0d u %0d v %0d vi %0d l %0d, ",
			$realtime, what, got.px, got.py, got.pz, got.nx, got.ny, got.nz,
			got.u, got.v, got.vi, got.last);
		$display("want pos %0d %0d %0d n %0d %0d %0d u %0d v %0d vi %0d l %0d",
			want.px, want.py, want.pz, want.nx, want.ny, want.nz,
			want.u, want.v, want.vi, want.last);
	endtask

	// Output check: every vertex beat must match the oldest pending vertex.
	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
				tex_u, tex_v, vertex_index, last_of_run};
			if (pending_vertices.size() == 0)
				report_mismatch("unexpected vertex", got, got);
			else if (got !== pending_vertices[0])
				report_mismatch("vertex mismatch", got, pending_vertices.pop_front());
			else
				void'(pending_vertices.pop_front());
		end
	end

	// Receiver: random stalls, or a long hold-off on request, so that the
	// output register fills and the block has to stall its input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = $urandom_range(99) >= recv_idle_pct;
		end
	end

	// Watchdog: a correct run never goes this long without any beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the next beat can follow back to back.
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic fin);
		logic rdy;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		point_x = x;
		point_y = y;
		point_z = z;
		final_point = fin;
		forever begin
			#1 rdy = in_ready;
			@(posedge clk);
			if (rdy)
				break;
			@(negedge clk);
		end
		predict_point(x, y, z, fin);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_vertices.size() != 0)
			@(negedge clk);
	endtask

	// Registers change only with the block idle. A lone first point gives no
	// vertex, so after draining the bench still waits out a full point time.
	task automatic write_reg(logic idx, logic [31:0] data);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		if (idx == REG_PATH_WIDTH)
			ribbon_width = data;
		else
			u_divisor = data[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = $urandom;
	endtask

	function automatic logic signed [31:0] rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		if (r < 35)
			return $urandom;
		return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
	endfunction

	// A random path: mostly small steps, with repeated points, vertical
	// segments, reversals and far jumps mixed in.
	task automatic send_path(int len);
		logic signed [31:0] px, py, pz, qx, qy, qz, nx, ny, nz;
		int r;
		px = rand_coord();
		py = rand_coord();
		pz = rand_coord();
		qx = px;
		qy = py;
		qz = pz;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (i == 0) begin
				nx = px; ny = py; nz = pz;
			end else if (r < 8) begin
				nx = px; ny = py; nz = pz;
			end else if (r < 16) begin
				nx = px; ny = rand_coord(); nz = pz;
			end else if (r < 24) begin
				nx = qx; ny = qy; nz = qz;
			end else if (r < 32) begin
				nx = rand_coord(); ny = rand_coord(); nz = rand_coord();
			end else begin
				nx = px + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
				ny = py + $signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
				nz = pz + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			end
			send_point(nx, ny, nz, i == len - 1);
			qx = px; qy = py; qz = pz;
			px = nx; py = ny; pz = nz;
		end
	endtask

	point_row_t directed_rows[$] = '{
		// Straight unit segment along x, checked against typed vertices.
		'{32'sd0, 32'sd0, 32'sd0, 1'b0}, '{32'sd65536, 32'sd0, 32'sd0, 1'b1},
		// A final point with nothing held.
		'{32'sd5, 32'sd5, 32'sd5, 1'b1},
		// Segment along up: no side vector and no normal.
		'{32'sd0, 32'sd0, 32'sd0, 1'b0}, '{32'sd0, 32'sd65536, 32'sd0, 1'b1},
		// Repeated point, then a step.
		'{32'sd100, 32'sd100, 32'sd100, 1'b0}, '{32'sd100, 32'sd100, 32'sd100, 1'b0},
		'{32'sd200, 32'sd100, 32'sd300, 1'b1},
		// Reversal: the interior tangent sums to zero.
		'{32'sd0, 32'sd0, 32'sd0, 1'b0}, '{32'sd65536, 32'sd0, 32'sd0, 1'b0},
		'{32'sd0, 32'sd0, 32'sd0, 1'b1},
		// Coordinate extremes.
		'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0},
		'{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0},
		'{32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b1},
		// A bent path in all three axes.
		'{32'sd0, 32'sd0, 32'sd0, 1'b0}, '{32'sd65536, 32'sd0, 32'sd65536, 1'b0},
		'{32'sd131072, 32'sd65536, 32'sd0, 1'b1}
	};

	// Straight x segment at reset width 1.0: side is 0.5 along -z, normal +y.
	vertex_t straight_x_vertices[4] = '{
		'{32'sd0, 32'sd0, 32'sd32768, 16'sd0, 16'sd16384, 16'sd0, 17'd0, 1'b0, 17'd0, 1'b0},
		'{32'sd0, 32'sd0, -32'sd32768, 16'sd0, 16'sd16384, 16'sd0, 17'd0, 1'b1, 17'd1, 1'b0},
		'{32'sd65536, 32'sd0, 32'sd32768, 16'sd0, 16'sd16384, 16'sd0, 17'd65536, 1'b0,
			17'd2, 1'b0},
		'{32'sd65536, 32'sd0, -32'sd32768, 16'sd0, 16'sd16384, 16'sd0, 17'd65536, 1'b1,
			17'd3, 1'b1}
	};

	initial begin
		int phase_end;
		int sel;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at reset register values, no idling.
		foreach (directed_rows[i]) begin
			send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
				directed_rows[i].fin);
			if (i == 1)
				foreach (straight_x_vertices[j])
					if (pending_vertices[j] !== straight_x_vertices[j])
						report_mismatch("predicted straight segment", pending_vertices[j],
							straight_x_vertices[j]);
		end

		// Random part in three phases of idling, with register settings rotated
		// through the extremes every few paths.
		sel = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 32 : (ph == 1 ? 65 : 0);
			recv_idle_pct = ph == 0 ? 65 : (ph == 1 ? 32 : 0);
			phase_end = beats_sent + 90;
			while (beats_sent < phase_end) begin
				case (sel % 5)
					0: begin
						write_reg(REG_PATH_WIDTH, 32'hffff_ffff);
						write_reg(REG_LAST_INDEX, 32'h0000_ffff);
					end
					1: begin
						write_reg(REG_PATH_WIDTH, 32'd0);
						write_reg(REG_LAST_INDEX, {$urandom_range(32'hffff) << 16});
					end
					2: begin
						write_reg(REG_PATH_WIDTH, $urandom);
						write_reg(REG_LAST_INDEX, $urandom_range(1, 8));
					end
					3: begin
						write_reg(REG_PATH_WIDTH, $urandom_range(0, 32'h0004_0000));
						write_reg(REG_LAST_INDEX, 32'd1);
					end
					default: begin
						write_reg(REG_PATH_WIDTH, 32'd65536);
						write_reg(REG_LAST_INDEX, $urandom);
					end
				endcase
				sel++;
				if (ph == 0 && sel == 2) begin
					// Long receiver hold-off while a long path keeps coming.
					hold_req = 1;
					send_path(8);
				end
				for (int n = 0; n < 6; n++) begin
					if ($urandom_range(9) == 0)
						send_path(1);
					else if ($urandom_range(9) == 0)
						send_path($urandom_range(8, 12));
					else
						send_path($urandom_range(2, 5));
					if (ph == 1 && n == 2)
						wait_drained();
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_vertices.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
rtl/rpv_pkg.sv
rtl/rpv_div.sv
rtl/rpv_unit.sv
rtl/path_ribbon_vertex_gen.sv
test/tb.sv
